// ===== hdl/tdv_pkg.sv =====
// ----------------------------------------------------------------------------
// tdv_pkg
// Shared widths, register codes, reset values and the sequencer program
// of the tom drum voice.
// ----------------------------------------------------------------------------
`default_nettype none

package tdv_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int WORD_W        = 32;
  localparam int VEL_W         = 17;
  localparam int SAMPLE_W      = 16;
  localparam int FREQ_W        = 26;
  localparam int DAMP_W        = 25;
  localparam int DECAY_W       = 25;
  localparam int CFG_DATA_W    = 26;
  localparam int CFG_IDX_W     = 2;
  localparam int STEP_W        = 3;

  localparam logic [VEL_W-1:0] VEL_ONE = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd2;

  localparam logic [FREQ_W-1:0]  FREQ_RESET  = 26'd382446;
  localparam logic [DAMP_W-1:0]  DAMP_RESET  = 25'd1677722;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 25'd16776201;

  // Operand A sources.
  localparam logic [1:0] A_FREQ = 2'd0;
  localparam logic [1:0] A_DAMP = 2'd1;
  localparam logic [1:0] A_BAND = 2'd2;
  localparam logic [1:0] A_ENV  = 2'd3;

  // Operand B sources.
  localparam logic [1:0] B_BAND  = 2'd0;
  localparam logic [1:0] B_HIGH  = 2'd1;
  localparam logic [1:0] B_ENV   = 2'd2;
  localparam logic [1:0] B_DECAY = 2'd3;

  // Writeback targets for the product of the previous step.
  localparam logic [2:0] WB_NONE = 3'd0;
  localparam logic [2:0] WB_LOW  = 3'd1;
  localparam logic [2:0] WB_HIGH = 3'd2;
  localparam logic [2:0] WB_BAND = 3'd3;
  localparam logic [2:0] WB_OUT  = 3'd4;
  localparam logic [2:0] WB_ENV  = 3'd5;

  // Step sequencing.
  localparam logic [1:0] J_NEXT    = 2'd0;
  localparam logic [1:0] J_WAIT    = 2'd1;
  localparam logic [1:0] J_OUTFREE = 2'd2;
  localparam logic [1:0] J_HOME    = 2'd3;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic [2:0] wb;
    logic [1:0] jmp;
  } ctrl_t;

  // One control word per step. A step loads the product register with
  // A*B when it advances and retires the product loaded by the step before.
  function automatic ctrl_t prog_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      3'd0:    w = '{a_sel: A_FREQ, b_sel: B_BAND,  wb: WB_NONE, jmp: J_WAIT};
      3'd1:    w = '{a_sel: A_DAMP, b_sel: B_BAND,  wb: WB_LOW,  jmp: J_NEXT};
      3'd2:    w = '{a_sel: A_FREQ, b_sel: B_BAND,  wb: WB_HIGH, jmp: J_NEXT};
      3'd3:    w = '{a_sel: A_FREQ, b_sel: B_HIGH,  wb: WB_NONE, jmp: J_NEXT};
      3'd4:    w = '{a_sel: A_FREQ, b_sel: B_BAND,  wb: WB_BAND, jmp: J_NEXT};
      3'd5:    w = '{a_sel: A_BAND, b_sel: B_ENV,   wb: WB_NONE, jmp: J_NEXT};
      3'd6:    w = '{a_sel: A_ENV,  b_sel: B_DECAY, wb: WB_OUT,  jmp: J_OUTFREE};
      3'd7:    w = '{a_sel: A_FREQ, b_sel: B_BAND,  wb: WB_ENV,  jmp: J_HOME};
      default: w = '{a_sel: A_FREQ, b_sel: B_BAND,  wb: WB_NONE, jmp: J_HOME};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tdv_in_if.sv =====
// ----------------------------------------------------------------------------
// tdv_in_if
// Tick channel: one beat per sample, with the strike flag and velocity.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdv_in_if;
  import tdv_pkg::*;

  logic             valid;
  logic             ready;
  logic             strike;
  logic [VEL_W-1:0] velocity;

  modport source (output valid, output strike, output velocity, input ready);
  modport sink   (input valid, input strike, input velocity, output ready);
endinterface

`default_nettype wire

// ===== hdl/tdv_out_if.sv =====
// ----------------------------------------------------------------------------
// tdv_out_if
// Sample channel: one signed audio sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdv_out_if;
  import tdv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/tdv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tdv_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdv_cfg_if;
  import tdv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tdv_mul.sv =====
// ----------------------------------------------------------------------------
// tdv_mul
// Shared signed fixed-point multiplier with a registered full product.
// ----------------------------------------------------------------------------
`default_nettype none

module tdv_mul #(
  parameter int FRAC_BITS = tdv_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               load,
  input  wire  signed [tdv_pkg::WORD_W-1:0] a,
  input  wire  signed [tdv_pkg::WORD_W-1:0] b,
  output logic        [tdv_pkg::WORD_W-1:0] q
);
  import tdv_pkg::*;

  logic signed [2*WORD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= $signed({{WORD_W{a[WORD_W-1]}}, a}) *
                $signed({{WORD_W{b[WORD_W-1]}}, b});
    end
  end

  // Arithmetic shift by the fraction width, keeping the low word.
  assign q = prod_r[FRAC_BITS +: WORD_W];

endmodule

`default_nettype wire

// ===== hdl/tom_drum_svf_voice_unit.sv =====
// ----------------------------------------------------------------------------
// tom_drum_svf_voice_unit
// Drum voice: state-variable filter struck by an impulse, shaped by a
// decaying envelope, one 16-bit sample per tick.
// ----------------------------------------------------------------------------
//
//   Channel   Modport  Payload              Role
//   in_bus    sink     strike, velocity     one beat per sample tick
//   out_bus   source   sample               one beat per accepted tick
//   cfg_bus   sink     index, data          coefficient writes, always ready
//
// For each tick a microcoded sequencer walks an 8-step program
// that drives five products through one shared 32x32 multiplier, and every
// product passes the multiplier's output register before it is retired.
// The tick channel is ready only on the program's first step. A finished
// sample sits in the output register, so the next tick is taken while it
// waits; the program stalls on its output step only if that register is
// still full. Reset is synchronous: it clears the filter, the envelope, the
// sequencer and the output valid, and restores the coefficient defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tom_drum_svf_voice_unit #(
  parameter int FRAC_BITS = tdv_pkg::FRAC_BITS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  tdv_in_if.sink    in_bus,
  tdv_out_if.source out_bus,
  tdv_cfg_if.sink   cfg_bus
);
  import tdv_pkg::*;

  // Impulse is velocity (Q16) times four in the internal fraction width.
  localparam int IMP_SHIFT = FRAC_BITS - 14;
  // The filter output is scaled down to 16-bit audio by this shift.
  localparam int OUT_SHIFT = FRAC_BITS - 14;
  localparam logic [WORD_W-1:0] ENV_ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] SAT_HI = 32'sd32767;
  localparam logic signed [WORD_W-1:0] SAT_LO = -32'sd32768;

  // Coefficient registers.
  logic [FREQ_W-1:0]  freq_r;
  logic [DAMP_W-1:0]  damp_r;
  logic [DECAY_W-1:0] decay_r;

  // Voice state and scratch values.
  logic [WORD_W-1:0] low_r, band_r, env_r, high_r, imp_r;
  logic [WORD_W-1:0] low_nxt, band_nxt, env_nxt, high_nxt, imp_nxt;

  logic [STEP_W-1:0] step_r, step_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;

  ctrl_t             cw;
  logic              go;
  logic              in_fire;
  logic              out_free;
  logic [WORD_W-1:0] op_a, op_b, prod;
  logic [VEL_W-1:0]  vel_clamped;
  logic signed [WORD_W-1:0] scaled;

  assign cw       = prog_word(step_r);
  assign in_fire  = in_bus.valid && (step_r == '0);
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready   = (step_r == '0);
  assign out_bus.valid  = out_valid_r;
  assign out_bus.sample = sample_r;
  assign cfg_bus.ready  = 1'b1;

  // The waiting steps advance only on their condition; the others always do.
  always_comb begin
    case (cw.jmp)
      J_WAIT:    go = in_fire;
      J_OUTFREE: go = out_free;
      J_NEXT:    go = 1'b1;
      J_HOME:    go = 1'b1;
      default:   go = 1'b1;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (cw.jmp == J_HOME) begin
      step_nxt = '0;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  // Coefficients are zero-extended, so they never enter as negative values.
  always_comb begin
    case (cw.a_sel)
      A_FREQ:  op_a = {{(WORD_W-FREQ_W){1'b0}}, freq_r};
      A_DAMP:  op_a = {{(WORD_W-DAMP_W){1'b0}}, damp_r};
      A_BAND:  op_a = band_r;
      A_ENV:   op_a = env_r;
      default: op_a = band_r;
    endcase
    case (cw.b_sel)
      B_BAND:  op_b = band_r;
      B_HIGH:  op_b = high_r;
      B_ENV:   op_b = env_r;
      B_DECAY: op_b = {{(WORD_W-DECAY_W){1'b0}}, decay_r};
      default: op_b = band_r;
    endcase
  end

  // The product register only moves when the program advances, so a stall
  // on the output step keeps the band times envelope product intact.
  tdv_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .load (go),
    .a    ($signed(op_a)),
    .b    ($signed(op_b)),
    .q    (prod)
  );

  assign vel_clamped = (in_bus.velocity > VEL_ONE) ? VEL_ONE : in_bus.velocity;
  assign scaled      = $signed(prod) >>> OUT_SHIFT;

  always_comb begin
    low_nxt       = low_r;
    band_nxt      = band_r;
    env_nxt       = env_r;
    high_nxt      = high_r;
    imp_nxt       = imp_r;
    sample_nxt    = sample_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;

    // A strike is applied as the tick is taken: the envelope restarts at
    // one and the impulse drives the filter for this tick only.
    if (in_fire) begin
      if (in_bus.strike) begin
        imp_nxt = {{(WORD_W-VEL_W){1'b0}}, vel_clamped} << IMP_SHIFT;
        env_nxt = ENV_ONE;
      end else begin
        imp_nxt = '0;
      end
    end

    if (go) begin
      case (cw.wb)
        WB_LOW:  low_nxt  = low_r + prod;
        WB_HIGH: high_nxt = imp_r - low_r - prod;
        WB_BAND: band_nxt = band_r + prod;
        WB_OUT: begin
          if (scaled > SAT_HI) begin
            sample_nxt = SAT_HI[SAMPLE_W-1:0];
          end else if (scaled < SAT_LO) begin
            sample_nxt = SAT_LO[SAMPLE_W-1:0];
          end else begin
            sample_nxt = scaled[SAMPLE_W-1:0];
          end
          out_valid_nxt = 1'b1;
        end
        WB_ENV:  env_nxt  = prod;
        WB_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= FREQ_RESET;
      damp_r      <= DAMP_RESET;
      decay_r     <= DECAY_RESET;
      low_r       <= '0;
      band_r      <= '0;
      env_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          REG_FREQ:  freq_r  <= cfg_bus.data[FREQ_W-1:0];
          REG_DAMP:  damp_r  <= cfg_bus.data[DAMP_W-1:0];
          REG_DECAY: decay_r <= cfg_bus.data[DECAY_W-1:0];
          default:   ;
        endcase
      end
      low_r       <= low_nxt;
      band_r      <= band_nxt;
      env_r       <= env_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r   <= high_nxt;
    imp_r    <= imp_nxt;
    sample_r <= sample_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/tdv_chk.sv =====
// ----------------------------------------------------------------------------
// tdv_chk
// Port-level checks of the drum voice, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdv_chk (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [tdv_pkg::SAMPLE_W-1:0]    out_sample
);

  // A tick keeps the sequencer busy for the rest of its program.
  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready
      ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("tick channel ready during a running program");

  // With no sample waiting, none is presented in the cycle right after a tick is taken.
  a_no_instant_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("sample appeared before the program could finish");

  // A held sample keeps its value until it is taken.
  a_sample_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("stalled sample changed or vanished");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("sample valid right after reset");

endmodule

bind tom_drum_svf_voice_unit tdv_chk u_tdv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_sample (out_bus.sample)
);

`default_nettype wire
